@@ rtl/i2cmbe_pkg.sv @@
package i2cmbe_pkg;

    // Command codes carried in the mode field
    typedef enum logic [2:0] {
        CMD_START = 3'd0,
        CMD_STOP  = 3'd1,
        CMD_SEND  = 3'd2,
        CMD_RECV  = 3'd3,
        CMD_SACK  = 3'd4,
        CMD_RACK  = 3'd5
    } t_cmd;

    localparam logic [2:0] PHASE_IDLE  = 3'd0;
    localparam logic [2:0] PHASE_FIRST = 3'd1;
    localparam logic [2:0] PHASE_SECOND = 3'd2;
    localparam logic [2:0] PHASE_THIRD = 3'd3;
    localparam logic [2:0] BIT_LAST    = 3'd7;
    localparam logic [7:0] WAIT_RESET  = 8'd3;

    // One input item: one tick of bus time
    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] mode;
        logic [7:0] tx_byte;
        logic       sda_in;
    } t_in_item;

    // One result item
    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_seen;
    } t_out_item;

    // Sequencer state
    typedef struct packed {
        t_cmd       cmd;
        logic [2:0] phase;
        logic [2:0] bit_count;
        logic [7:0] wait_count;
        logic [7:0] tx_shift;
        logic [7:0] rx_shift;
        logic       scl_level;
        logic       sda_level;
        logic       ack_bit;
    } t_state;

    // Final phase of each command's segment list
    function automatic logic [2:0] last_phase(input t_cmd cmd);
        logic [2:0] res;
        unique case (cmd)
            CMD_START: res = 3'd4;
            CMD_STOP:  res = 3'd3;
            CMD_SEND:  res = 3'd3;
            default:   res = 3'd2;
        endcase
        return res;
    endfunction

endpackage

@@ rtl/i2c_master_bit_engine_unit.sv @@
// Latency: a result is valid in the cycle after its item is accepted.
// Throughput: one item per cycle unless the output stalls; the sequencer step
// is one registered i2cmbe_step pass; result register refilled while taken.
// Reset: sequencer idle, SCL and SDA high, shift registers and ack cleared,
// wait_ticks set to 3, no result pending.
module i2c_master_bit_engine_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  i2cmbe_pkg::t_in_item  i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output i2cmbe_pkg::t_out_item o_out_item,
    input  logic                  i_cfg_we,
    input  logic [7:0]            i_cfg_data
);

    i2cmbe_pkg::t_state    r_state;
    i2cmbe_pkg::t_state    n_state;
    i2cmbe_pkg::t_out_item r_out_item;
    i2cmbe_pkg::t_out_item n_out_item;
    logic                  r_out_valid;
    logic [7:0]            r_wait_ticks;
    logic                  in_accept;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_accept  = i_in_valid && o_in_ready;

    i2cmbe_step u_step (
        .i_state      (r_state),
        .i_item       (i_in_item),
        .i_wait_ticks (r_wait_ticks),
        .o_state      (n_state),
        .o_result     (n_out_item)
    );

    // Wait length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait_ticks <= i2cmbe_pkg::WAIT_RESET;
        end else if (i_cfg_we) begin
            r_wait_ticks <= i_cfg_data;
        end
    end

    // Sequencer state advances once per accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{cmd: i2cmbe_pkg::CMD_START, scl_level: 1'b1, sda_level: 1'b1,
                         default: '0};
        end else if (in_accept) begin
            r_state <= n_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // A completing item never reports busy
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_item.done_res) |-> !r_out_item.busy_res)
        else $error("done and busy reported together");

    // Idle sequencer holds no pending wait
    a_idle_wait_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == i2cmbe_pkg::PHASE_IDLE) |-> (r_state.wait_count == 8'd0))
        else $error("wait count left over in idle");

    // Bit count only moves for byte commands
    a_bits_byte_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.bit_count != 3'd0) |->
        (r_state.cmd == i2cmbe_pkg::CMD_SEND || r_state.cmd == i2cmbe_pkg::CMD_RECV))
        else $error("bit count set outside a byte command");

    // Busy result means the sequencer is still active
    a_busy_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> (r_out_item.busy_res == (r_state.phase != i2cmbe_pkg::PHASE_IDLE)))
        else $error("busy result disagrees with sequencer phase");

endmodule

@@ rtl/i2cmbe_step.sv @@
module i2cmbe_step (
    input  i2cmbe_pkg::t_state    i_state,
    input  i2cmbe_pkg::t_in_item  i_item,
    input  logic [7:0]            i_wait_ticks,
    output i2cmbe_pkg::t_state    o_state,
    output i2cmbe_pkg::t_out_item o_result
);

    i2cmbe_pkg::t_state s;
    logic               done;
    logic [7:0]         wait_load;

    // Zero wait behaves as one tick
    assign wait_load = (i_wait_ticks == 8'd0) ? 8'd1 : i_wait_ticks;

    always_comb begin
        s    = i_state;
        done = 1'b0;

        // Command start, only from idle and only for defined modes
        if (s.phase == i2cmbe_pkg::PHASE_IDLE && i_item.cmd_valid &&
            i_item.mode <= 3'(i2cmbe_pkg::CMD_RACK)) begin
            s.cmd        = i2cmbe_pkg::t_cmd'(i_item.mode);
            s.tx_shift   = i_item.tx_byte;
            if (i_item.mode == 3'(i2cmbe_pkg::CMD_RECV)) begin
                s.rx_shift = 8'd0;
            end
            s.bit_count  = 3'd0;
            s.wait_count = 8'd0;
            s.phase      = i2cmbe_pkg::PHASE_FIRST;
        end

        if (s.phase != i2cmbe_pkg::PHASE_IDLE) begin
            // Line change on the first tick of each segment
            if (s.wait_count == 8'd0) begin
                unique case (s.cmd)
                    i2cmbe_pkg::CMD_START: begin
                        priority if (s.phase == i2cmbe_pkg::PHASE_FIRST) s.sda_level = 1'b1;
                        else if (s.phase == i2cmbe_pkg::PHASE_SECOND) s.scl_level = 1'b1;
                        else if (s.phase == i2cmbe_pkg::PHASE_THIRD) s.sda_level = 1'b0;
                        else s.scl_level = 1'b0;
                    end
                    i2cmbe_pkg::CMD_STOP: begin
                        priority if (s.phase == i2cmbe_pkg::PHASE_FIRST) s.sda_level = 1'b0;
                        else if (s.phase == i2cmbe_pkg::PHASE_SECOND) s.scl_level = 1'b1;
                        else s.sda_level = 1'b1;
                    end
                    i2cmbe_pkg::CMD_SEND: begin
                        priority if (s.phase == i2cmbe_pkg::PHASE_FIRST) begin
                            s.sda_level = s.tx_shift[7];
                        end else if (s.phase == i2cmbe_pkg::PHASE_SECOND) begin
                            s.scl_level = 1'b1;
                        end else begin
                            s.scl_level = 1'b0;
                            s.tx_shift  = {s.tx_shift[6:0], 1'b0};
                        end
                    end
                    i2cmbe_pkg::CMD_RECV: begin
                        if (s.phase == i2cmbe_pkg::PHASE_FIRST) begin
                            s.scl_level = 1'b1;
                        end else begin
                            s.sda_level = 1'b1;
                            s.rx_shift  = {s.rx_shift[6:0], i_item.sda_in};
                            s.scl_level = 1'b0;
                        end
                    end
                    i2cmbe_pkg::CMD_SACK: begin
                        if (s.phase == i2cmbe_pkg::PHASE_FIRST) begin
                            s.sda_level = s.tx_shift[0];
                            s.scl_level = 1'b1;
                        end else begin
                            s.scl_level = 1'b0;
                        end
                    end
                    // read ack; also serves the unused codes
                    default: begin
                        if (s.phase == i2cmbe_pkg::PHASE_FIRST) begin
                            s.scl_level = 1'b1;
                        end else begin
                            s.sda_level = 1'b1;
                            s.ack_bit   = i_item.sda_in;
                            s.scl_level = 1'b0;
                        end
                    end
                endcase
                s.wait_count = wait_load;
            end

            s.wait_count = s.wait_count - 8'd1;

            // Segment end: next phase, next bit, or command done
            if (s.wait_count == 8'd0) begin
                if (s.phase >= i2cmbe_pkg::last_phase(s.cmd)) begin
                    if ((s.cmd == i2cmbe_pkg::CMD_SEND || s.cmd == i2cmbe_pkg::CMD_RECV) &&
                        s.bit_count < i2cmbe_pkg::BIT_LAST) begin
                        s.bit_count = s.bit_count + 3'd1;
                        s.phase     = i2cmbe_pkg::PHASE_FIRST;
                    end else begin
                        s.phase = i2cmbe_pkg::PHASE_IDLE;
                        done    = 1'b1;
                    end
                end else begin
                    s.phase = s.phase + 3'd1;
                end
            end
        end
    end

    assign o_state = s;

    // Result fields from the updated state
    always_comb begin
        o_result.scl_out  = s.scl_level;
        o_result.sda_out  = s.sda_level;
        o_result.busy_res = (s.phase != i2cmbe_pkg::PHASE_IDLE);
        o_result.done_res = done;
        o_result.rx_byte  = s.rx_shift;
        o_result.ack_seen = s.ack_bit;
    end

endmodule

@@ bench/i2c_master_bit_engine_unit_test.sv @@
module i2c_master_bit_engine_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Phase 4 closes a start; modes 6 and 7 are reserved
    localparam logic [2:0] PH_FOURTH  = 3'd4;
    localparam logic [2:0] MODE_RSVD6 = 3'd6;
    localparam logic [2:0] MODE_RSVD7 = 3'd7;
    // Lines high, idle, nothing received yet
    localparam i2cmbe_pkg::t_out_item AT_REST = {1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0};

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    i2cmbe_pkg::t_in_item  in_item = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    i2cmbe_pkg::t_out_item out_item;
    logic                  cfg_we = 1'b0;
    logic [7:0]            cfg_data = 8'h00;

    // Directed row: one tick item, repeated reps times
    typedef struct {
        i2cmbe_pkg::t_in_item it;
        int unsigned          reps;
        bit                   at_rest;
    } t_row;

    t_row                  dir_rows[$];
    i2cmbe_pkg::t_out_item pending_q[$];
    int                    bad = 0;
    int                    hold = 0;
    bit                    quiet = 1'b0;
    bit                    sending = 1'b0;

    // Predicted sequencer state
    i2cmbe_pkg::t_cmd bus_cmd = i2cmbe_pkg::CMD_START;
    logic [2:0]       bus_phase = i2cmbe_pkg::PHASE_IDLE;
    logic [2:0]       bus_bits = 3'd0;
    logic [7:0]       bus_wait = 8'd0;
    logic [7:0]       bus_tx = 8'd0;
    logic [7:0]       bus_rx = 8'd0;
    logic             bus_scl = 1'b1;
    logic             bus_sda = 1'b1;
    logic             bus_ack = 1'b0;
    logic [7:0]       bus_wait_len = i2cmbe_pkg::WAIT_RESET;

    always #1 clk = ~clk;

    i2c_master_bit_engine_unit DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    // Advance the bus sequencer by one tick and return the pin/status item
    function automatic i2cmbe_pkg::t_out_item bus_tick(input i2cmbe_pkg::t_in_item it);
        i2cmbe_pkg::t_out_item r;
        logic                  fin;
        logic [2:0]            end_phase;
        fin = 1'b0;
        if (bus_phase == i2cmbe_pkg::PHASE_IDLE && it.cmd_valid &&
            it.mode <= i2cmbe_pkg::CMD_RACK) begin
            bus_cmd = i2cmbe_pkg::t_cmd'(it.mode);
            bus_tx = it.tx_byte;
            if (bus_cmd == i2cmbe_pkg::CMD_RECV) bus_rx = 8'd0;
            bus_bits = 3'd0;
            bus_wait = 8'd0;
            bus_phase = i2cmbe_pkg::PHASE_FIRST;
        end
        if (bus_phase != i2cmbe_pkg::PHASE_IDLE) begin
            // line changes land on the first tick of each segment
            if (bus_wait == 8'd0) begin
                case (bus_cmd)
                    i2cmbe_pkg::CMD_START: begin
                        if (bus_phase == i2cmbe_pkg::PHASE_FIRST) bus_sda = 1'b1;
                        else if (bus_phase == i2cmbe_pkg::PHASE_SECOND) bus_scl = 1'b1;
                        else if (bus_phase == i2cmbe_pkg::PHASE_THIRD) bus_sda = 1'b0;
                        else bus_scl = 1'b0;
                    end
                    i2cmbe_pkg::CMD_STOP: begin
                        if (bus_phase == i2cmbe_pkg::PHASE_FIRST) bus_sda = 1'b0;
                        else if (bus_phase == i2cmbe_pkg::PHASE_SECOND) bus_scl = 1'b1;
                        else bus_sda = 1'b1;
                    end
                    i2cmbe_pkg::CMD_SEND: begin
                        if (bus_phase == i2cmbe_pkg::PHASE_FIRST) bus_sda = bus_tx[7];
                        else if (bus_phase == i2cmbe_pkg::PHASE_SECOND) bus_scl = 1'b1;
                        else begin
                            bus_scl = 1'b0;
                            bus_tx = {bus_tx[6:0], 1'b0};
                        end
                    end
                    i2cmbe_pkg::CMD_RECV: begin
                        if (bus_phase == i2cmbe_pkg::PHASE_FIRST) bus_scl = 1'b1;
                        else begin
                            bus_sda = 1'b1;
                            bus_rx = {bus_rx[6:0], it.sda_in};
                            bus_scl = 1'b0;
                        end
                    end
                    i2cmbe_pkg::CMD_SACK: begin
                        if (bus_phase == i2cmbe_pkg::PHASE_FIRST) begin
                            bus_sda = bus_tx[0];
                            bus_scl = 1'b1;
                        end else bus_scl = 1'b0;
                    end
                    default: begin
                        if (bus_phase == i2cmbe_pkg::PHASE_FIRST) bus_scl = 1'b1;
                        else begin
                            bus_sda = 1'b1;
                            bus_ack = it.sda_in;
                            bus_scl = 1'b0;
                        end
                    end
                endcase
                // zero wait behaves as one tick
                bus_wait = (bus_wait_len == 8'd0) ? 8'd1 : bus_wait_len;
            end
            bus_wait = bus_wait - 8'd1;
            if (bus_wait == 8'd0) begin
                case (bus_cmd)
                    i2cmbe_pkg::CMD_START: end_phase = PH_FOURTH;
                    i2cmbe_pkg::CMD_STOP,
                    i2cmbe_pkg::CMD_SEND:  end_phase = i2cmbe_pkg::PHASE_THIRD;
                    default:               end_phase = i2cmbe_pkg::PHASE_SECOND;
                endcase
                if (bus_phase >= end_phase) begin
                    if ((bus_cmd == i2cmbe_pkg::CMD_SEND || bus_cmd == i2cmbe_pkg::CMD_RECV) &&
                        bus_bits < i2cmbe_pkg::BIT_LAST) begin
                        bus_bits = bus_bits + 3'd1;
                        bus_phase = i2cmbe_pkg::PHASE_FIRST;
                    end else begin
                        bus_phase = i2cmbe_pkg::PHASE_IDLE;
                        fin = 1'b1;
                    end
                end else begin
                    bus_phase = bus_phase + 3'd1;
                end
            end
        end
        r.scl_out = bus_scl;
        r.sda_out = bus_sda;
        r.busy_res = (bus_phase != i2cmbe_pkg::PHASE_IDLE);
        r.done_res = fin;
        r.rx_byte = bus_rx;
        r.ack_seen = bus_ack;
        return r;
    endfunction

    function automatic void add_row(input logic valid, input logic [2:0] mode,
                                    input logic [7:0] tx, input logic sda,
                                    input int unsigned reps, input bit at_rest);
        t_row row;
        row.it.cmd_valid = valid;
        row.it.mode = mode;
        row.it.tx_byte = tx;
        row.it.sda_in = sda;
        row.reps = reps;
        row.at_rest = at_rest;
        dir_rows.push_back(row);
    endfunction

    // Offer one tick item, wait for it to be taken, queue its expected result
    task automatic push_item(input i2cmbe_pkg::t_in_item it, input bit at_rest);
        i2cmbe_pkg::t_out_item want;
        in_valid <= 1'b1;
        in_item <= it;
        sending = 1'b1;
        do @(posedge clk); while (!in_ready);
        want = bus_tick(it);
        pending_q.push_back(at_rest ? AT_REST : want);
    endtask

    // Random input-side idle burst
    task automatic take_gap();
        if (!quiet && $urandom_range(0, 19) == 0) begin
            in_valid <= 1'b0;
            sending = 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
    endtask

    // Register write once every queued result has come back
    task automatic set_wait(input logic [7:0] v);
        if (sending) begin
            in_valid <= 1'b0;
            sending = 1'b0;
        end
        while (pending_q.size() != 0) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        bus_wait_len = v;
    endtask

    // Mostly real commands when idle; stray requests while busy
    task automatic run_random(input logic [7:0] wlen, input int unsigned n);
        i2cmbe_pkg::t_in_item it;
        set_wait(wlen);
        repeat (n) begin
            if (bus_phase == i2cmbe_pkg::PHASE_IDLE) begin
                it.cmd_valid = ($urandom_range(0, 9) < 8);
                it.mode = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7))
                                                       : 3'($urandom_range(0, 5));
            end else begin
                it.cmd_valid = ($urandom_range(0, 4) == 0);
                it.mode = 3'($urandom_range(0, 7));
            end
            it.tx_byte = 8'($urandom);
            it.sda_in = 1'($urandom);
            push_item(it, 1'b0);
            take_gap();
        end
    endtask

    // Result side: compare against the oldest expectation, stall at random
    always @(posedge clk) begin : result_check
        i2cmbe_pkg::t_out_item want;
        if (out_valid && out_ready) begin
            if (pending_q.size() == 0) begin
                $error("result item with nothing expected");
                bad++;
            end else begin
                want = pending_q.pop_front();
                if (out_item.scl_out !== want.scl_out) begin
                    $error("scl_out: expected %0h, got %0h", want.scl_out, out_item.scl_out);
                    bad++;
                end
                if (out_item.sda_out !== want.sda_out) begin
                    $error("sda_out: expected %0h, got %0h", want.sda_out, out_item.sda_out);
                    bad++;
                end
                if (out_item.busy_res !== want.busy_res) begin
                    $error("busy_res: expected %0h, got %0h", want.busy_res, out_item.busy_res);
                    bad++;
                end
                if (out_item.done_res !== want.done_res) begin
                    $error("done_res: expected %0h, got %0h", want.done_res, out_item.done_res);
                    bad++;
                end
                if (out_item.rx_byte !== want.rx_byte) begin
                    $error("rx_byte: expected %0h, got %0h", want.rx_byte, out_item.rx_byte);
                    bad++;
                end
                if (out_item.ack_seen !== want.ack_seen) begin
                    $error("ack_seen: expected %0h, got %0h", want.ack_seen, out_item.ack_seen);
                    bad++;
                end
            end
        end
        if (hold != 0) begin
            hold--;
            out_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 24) == 0) begin
            hold = $urandom_range(0, 17);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Stimulus
    initial begin
        // at rest after reset, reserved modes ignored
        add_row(1'b0, i2cmbe_pkg::CMD_START, 8'h00, 1'b0, 2, 1'b1);
        add_row(1'b1, MODE_RSVD6, 8'hFF, 1'b1, 1, 1'b1);
        add_row(1'b1, MODE_RSVD7, 8'hFF, 1'b0, 1, 1'b1);
        // start, with a stop requested while it runs
        add_row(1'b1, i2cmbe_pkg::CMD_START, 8'h00, 1'b1, 1, 1'b0);
        add_row(1'b1, i2cmbe_pkg::CMD_STOP, 8'h00, 1'b1, 3, 1'b0);
        // send all ones, receive requested throughout (ignored)
        add_row(1'b1, i2cmbe_pkg::CMD_SEND, 8'hFF, 1'b0, 1, 1'b0);
        add_row(1'b1, i2cmbe_pkg::CMD_RECV, 8'h00, 1'b0, 23, 1'b0);
        // ack read low, then high
        add_row(1'b1, i2cmbe_pkg::CMD_RACK, 8'h00, 1'b0, 2, 1'b0);
        add_row(1'b1, i2cmbe_pkg::CMD_RACK, 8'hFF, 1'b1, 2, 1'b0);
        // receive all ones, then all zeros
        add_row(1'b1, i2cmbe_pkg::CMD_RECV, 8'h00, 1'b1, 16, 1'b0);
        add_row(1'b1, i2cmbe_pkg::CMD_RECV, 8'hFF, 1'b0, 16, 1'b0);
        // send ack high and low
        add_row(1'b1, i2cmbe_pkg::CMD_SACK, 8'h01, 1'b0, 2, 1'b0);
        add_row(1'b1, i2cmbe_pkg::CMD_SACK, 8'hFE, 1'b1, 2, 1'b0);
        // send all zeros, then stop
        add_row(1'b1, i2cmbe_pkg::CMD_SEND, 8'h00, 1'b1, 24, 1'b0);
        add_row(1'b1, i2cmbe_pkg::CMD_STOP, 8'hFF, 1'b1, 3, 1'b0);
        add_row(1'b0, i2cmbe_pkg::CMD_START, 8'h00, 1'b0, 2, 1'b0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed part runs with a zero wait, which acts as one tick
        set_wait(8'd0);
        foreach (dir_rows[i]) begin
            repeat (dir_rows[i].reps) begin
                push_item(dir_rows[i].it, dir_rows[i].at_rest);
                take_gap();
            end
        end

        run_random(8'd1, 300);
        run_random(8'd2, 250);
        run_random(8'd255, 150);
        run_random(8'd0, 200);
        run_random(8'($urandom_range(4, 9)), 250);
        quiet = 1'b1;
        run_random(8'd1, 350);

        // drain
        if (sending) begin
            in_valid <= 1'b0;
            sending = 1'b0;
        end
        while (pending_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        if (bad == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
